// ----- src/crs_enc_pkg.sv -----
// ----------------------------------------------------------------------------
// crs_enc_pkg
// Shared constants, types and field helpers of the Cauchy RS erasure encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package crs_enc_pkg;

    localparam int ROWS_DEF        = 16;
    localparam int MAX_SYMBOLS_DEF = 1024;

    localparam int SYM_W   = 16;
    localparam int POLY_W  = 17;
    localparam int NUM_W   = 16;
    localparam int CNT_W   = 5;
    localparam int POS_W   = 10;
    localparam int ROW_W   = 4;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 17;
    localparam int STEP_BITS = 4;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_WIDE_FIELD     = 3'd0;
    localparam logic [CIDX_W-1:0] REG_FIELD_POLY     = 3'd1;
    localparam logic [CIDX_W-1:0] REG_FIRST_RECOVERY = 3'd2;
    localparam logic [CIDX_W-1:0] REG_RECOVERY_COUNT = 3'd3;
    localparam logic [CIDX_W-1:0] REG_BLOCK_OFFSET   = 3'd4;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SETUP = 8'b0000_0010,
        S_SQ    = 8'b0000_0100,
        S_MU    = 8'b0000_1000,
        S_PROD  = 8'b0001_0000,
        S_WR    = 8'b0010_0000,
        S_RDQ   = 8'b0100_0000,
        S_RDO   = 8'b1000_0000
    } t_state;

    // Multiply by x with reduction; red holds the low polynomial bits, masked.
    function automatic logic [SYM_W-1:0] f_xtime(
        input logic [SYM_W-1:0] a,
        input logic             wide,
        input logic [SYM_W-1:0] red
    );
        logic             carry;
        logic [SYM_W-1:0] s;
        carry = wide ? a[15] : a[7];
        s = {a[14:0], 1'b0};
        if (!wide) begin
            s[15:8] = 8'h00;
        end
        if (carry) begin
            s = s ^ red;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- src/cauchy_rs_erasure_encoder_top.sv -----
// ----------------------------------------------------------------------------
// cauchy_rs_erasure_encoder_top
// Cauchy Reed-Solomon recovery encoder over GF(2^8) / GF(2^16).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): one transfer is a feed (cmd 0)
//   or a read (cmd 1). A feed folds symbol * inv(column ^ row term) into every
//   active recovery row at that position; a read returns one stored symbol.
//   Output channel (o_out_valid / i_out_stall): one transfer per read.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; write only
//   while the block is idle.
// Timing:
//   All work runs on one shared GF multiplier that retires 4 bits a cycle.
//   Per row: setup, (m-1) square/multiply pairs for the inverse, one product,
//   one write. A feed runs these steps for each active row in turn; a read
//   passes through S_RDQ and S_RDO to its result register.
// Reset: control state and config registers return to their reset values;
//   the recovery store is not cleared and must be written (block index 0)
//   before it is read or accumulated.
// Stall: a finished read result waits in the output register; the block
//   accepts new items meanwhile and only blocks when a second read result
//   finds the register still full.
// ----------------------------------------------------------------------------
`default_nettype none

module cauchy_rs_erasure_encoder_top #(
    parameter int ROWS        = crs_enc_pkg::ROWS_DEF,
    parameter int MAX_SYMBOLS = crs_enc_pkg::MAX_SYMBOLS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire                               i_cmd,
    input  wire  [crs_enc_pkg::NUM_W-1:0]     i_block_index,
    input  wire  [crs_enc_pkg::POS_W-1:0]     i_position,
    input  wire  [crs_enc_pkg::SYM_W-1:0]     i_symbol,
    input  wire  [crs_enc_pkg::ROW_W-1:0]     i_row,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [crs_enc_pkg::SYM_W-1:0]     o_value,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [crs_enc_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire  [crs_enc_pkg::CDATA_W-1:0]   i_cfg_data
);
    import crs_enc_pkg::*;

    localparam int DEPTH = ROWS * MAX_SYMBOLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int YW    = $clog2(ROWS + 1);

    // configuration
    logic              r_wide;
    logic [POLY_W-1:0] r_poly;
    logic [NUM_W-1:0]  r_first;
    logic [CNT_W-1:0]  r_count;
    logic [NUM_W-1:0]  r_offset;

    t_state           r_state;
    logic [YW-1:0]    r_y;
    logic [YW-1:0]    r_rows;
    logic [AW-1:0]    r_addr;
    logic [SYM_W-1:0] r_sym;
    logic [NUM_W-1:0] r_bidx;
    logic [SYM_W-1:0] r_sq;
    logic [SYM_W-1:0] r_inv;
    logic [SYM_W-1:0] r_prod;
    logic [3:0]       r_ic;
    logic             r_zero;
    // shared multiplier
    logic             r_mbusy;
    logic [SYM_W-1:0] r_ma;
    logic [SYM_W-1:0] r_mb;
    logic [SYM_W-1:0] r_macc;
    logic [CNT_W-1:0] r_mcnt;
    // output register
    logic             r_out_valid;
    logic [SYM_W-1:0] r_out_value;

    logic [SYM_W-1:0] mem [DEPTH];
    logic [SYM_W-1:0] r_rdata;

    logic [SYM_W-1:0] mask;
    logic [SYM_W-1:0] red;
    logic [CNT_W-1:0] bits;
    logic [3:0]       ic_last;
    logic             in_xfer;
    logic             out_free;
    logic [SYM_W-1:0] n_ma;
    logic [SYM_W-1:0] n_mb;
    logic [SYM_W-1:0] n_macc;
    logic [CNT_W-1:0] n_mcnt;
    logic             m_done;
    logic [NUM_W-1:0] x_abs;
    logic [NUM_W-1:0] y_sum;
    logic [SYM_W-1:0] base;
    logic             we;
    logic [SYM_W-1:0] wdata;
    logic [YW-1:0]    n_rows;

    assign mask    = r_wide ? 16'hFFFF : 16'h00FF;
    assign red     = r_poly[SYM_W-1:0] & mask;
    assign bits    = r_wide ? 5'd16 : 5'd8;
    assign ic_last = r_wide ? 4'd15 : 4'd7;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;

    assign n_rows = (32'(r_count) > ROWS) ? YW'(ROWS) : YW'(r_count);

    // one multiplier step: four bits of b
    always_comb begin
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_macc = r_macc;
        for (int k = 0; k < STEP_BITS; k++) begin
            if (n_mb[0]) begin
                n_macc = n_macc ^ n_ma;
            end
            n_ma = f_xtime(n_ma, r_wide, red);
            n_mb = n_mb >> 1;
        end
        n_mcnt = r_mcnt + CNT_W'(STEP_BITS);
        m_done = r_mbusy && (n_mcnt == bits);
    end

    // coefficient base for the current row
    assign x_abs = r_bidx + r_offset;
    assign y_sum = r_first + NUM_W'(r_y);
    assign base  = (x_abs & mask) ^ ((mask - y_sum) & mask);

    assign we    = (r_state == S_WR);
    assign wdata = (r_bidx == '0) ? r_prod : ((r_rdata ^ r_prod) & mask);

    // recovery store
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_addr] <= wdata;
        end
        r_rdata <= mem[r_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide   <= 1'b1;
            r_poly   <= 17'h1100B;
            r_first  <= '0;
            r_count  <= 5'd1;
            r_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WIDE_FIELD:     r_wide   <= i_cfg_data[0];
                REG_FIELD_POLY:     r_poly   <= i_cfg_data[POLY_W-1:0];
                REG_FIRST_RECOVERY: r_first  <= i_cfg_data[NUM_W-1:0];
                REG_RECOVERY_COUNT: r_count  <= i_cfg_data[CNT_W-1:0];
                REG_BLOCK_OFFSET:   r_offset <= i_cfg_data[NUM_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mbusy     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_bidx <= i_block_index;
                        r_sym  <= i_symbol & mask;
                        r_y    <= '0;
                        r_rows <= n_rows;
                        if (i_cmd == CMD_READ) begin
                            r_zero  <= !((32'(i_row) < ROWS) &&
                                         (32'(i_position) < MAX_SYMBOLS));
                            r_addr  <= AW'(AW'(i_row) * AW'(MAX_SYMBOLS) + AW'(i_position));
                            r_state <= S_RDQ;
                        end else if ((32'(i_position) < MAX_SYMBOLS) && (n_rows != '0)) begin
                            r_addr  <= AW'(i_position);
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_sq    <= base;
                    r_inv   <= 16'h0001;
                    r_ic    <= 4'd1;
                    r_state <= S_SQ;
                end
                S_SQ, S_MU, S_PROD: begin
                    if (!r_mbusy) begin
                        r_mbusy <= 1'b1;
                        r_macc  <= '0;
                        r_mcnt  <= '0;
                        if (r_state == S_SQ) begin
                            r_ma <= r_sq;
                            r_mb <= r_sq;
                        end else if (r_state == S_MU) begin
                            r_ma <= r_inv;
                            r_mb <= r_sq;
                        end else begin
                            r_ma <= r_sym;
                            r_mb <= r_inv;
                        end
                    end else begin
                        r_ma   <= n_ma;
                        r_mb   <= n_mb;
                        r_macc <= n_macc;
                        r_mcnt <= n_mcnt;
                        if (m_done) begin
                            r_mbusy <= 1'b0;
                            if (r_state == S_SQ) begin
                                r_sq    <= n_macc;
                                r_state <= S_MU;
                            end else if (r_state == S_MU) begin
                                r_inv <= n_macc;
                                r_ic  <= r_ic + 4'd1;
                                r_state <= (r_ic == ic_last) ? S_PROD : S_SQ;
                            end else begin
                                r_prod  <= n_macc;
                                r_state <= S_WR;
                            end
                        end
                    end
                end
                S_WR: begin
                    r_y    <= r_y + YW'(1);
                    r_addr <= r_addr + AW'(MAX_SYMBOLS);
                    r_state <= (r_y + YW'(1) == r_rows) ? S_IDLE : S_SETUP;
                end
                S_RDQ: begin
                    r_state <= S_RDO;
                end
                S_RDO: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_zero ? '0 : r_rdata;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_mbusy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mbusy |-> (r_state == S_SQ || r_state == S_MU || r_state == S_PROD))
        else $error("multiplier busy outside a multiply state");

    a_mcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mbusy |-> (r_mcnt < bits))
        else $error("multiplier bit count overran field width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_y < r_rows))
        else $error("write to row beyond active count");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDO && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("read result not loaded");

endmodule

`default_nettype wire
